FILE: src/stdec_pkg.sv
`timescale 1ns / 1ps

package stdec_pkg;

  // Header bytes and decode constants
  localparam logic [7:0]  MagicByte  = 8'hFE;
  localparam logic [15:0] MarkUnit   = 16'hFEFF;
  localparam logic [15:0] SmallLimit = 16'h0020;
  localparam logic [15:0] OddMask    = 16'hAAAA;
  localparam logic [15:0] EvenMask   = 16'h5555;

  // Header phases; anything above the last reserved byte is the data phase
  localparam logic [2:0] PhMagic0 = 3'd0;
  localparam logic [2:0] PhMagic1 = 3'd1;
  localparam logic [2:0] PhMode   = 3'd2;
  localparam logic [2:0] PhRsv0   = 3'd3;
  localparam logic [2:0] PhRsv1   = 3'd4;
  localparam logic [2:0] PhData   = 3'd5;

  // Result status codes
  localparam logic [2:0] StUnit     = 3'd0;
  localparam logic [2:0] StDone     = 3'd1;
  localparam logic [2:0] StBadMagic = 3'd2;
  localparam logic [2:0] StBadMode  = 3'd3;
  localparam logic [2:0] StShort    = 3'd4;

  // Result queue depth
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [2:0] header_phase;
    logic       mode_bit;
    logic [7:0] low_half;
    logic       half_pending;
    logic       discarding;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic        final_res;
  } result_t;

endpackage

FILE: src/stdec_step.sv
`timescale 1ns / 1ps

module stdec_step (
  input  stdec_pkg::dec_state_t state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_file_i,
  output stdec_pkg::dec_state_t state_o,
  output logic [1:0]            res_count_o,
  output stdec_pkg::result_t    res0_o,
  output stdec_pkg::result_t    res1_o
);

  logic        fail_en;
  logic [2:0]  fail_st;
  logic [15:0] unit;
  logic [15:0] decoded;

  // Assemble the little-endian unit and decode it for the current mode
  assign unit = {data_byte_i, state_i.low_half};

  always_comb begin
    if (state_i.mode_bit) begin
      decoded = ((unit & stdec_pkg::OddMask) >> 1) | ((unit & stdec_pkg::EvenMask) << 1);
    end else if (unit >= stdec_pkg::SmallLimit) begin
      decoded = unit ^ {unit[7:1], 1'b0, 8'h01};
    end else begin
      decoded = unit;
    end
  end

  // Walk the header, pair data bytes, flag errors
  always_comb begin
    state_o     = state_i;
    res_count_o = 2'd0;
    res0_o      = '0;
    res1_o      = '0;
    fail_en     = 1'b0;
    fail_st     = stdec_pkg::StShort;

    if (state_i.discarding) begin
      if (end_of_file_i) begin
        state_o = '0;
      end
    end else begin
      case (state_i.header_phase)
        stdec_pkg::PhMagic0: begin
          if (end_of_file_i) begin
            fail_en = 1'b1;
          end else begin
            state_o.low_half     = {7'd0, data_byte_i != stdec_pkg::MagicByte};
            state_o.header_phase = stdec_pkg::PhMagic1;
          end
        end
        stdec_pkg::PhMagic1: begin
          if (end_of_file_i) begin
            fail_en = 1'b1;
          end else if (state_i.low_half != 8'd0 || data_byte_i != stdec_pkg::MagicByte) begin
            fail_en = 1'b1;
            fail_st = stdec_pkg::StBadMagic;
          end else begin
            state_o.low_half     = 8'd0;
            state_o.header_phase = stdec_pkg::PhMode;
          end
        end
        stdec_pkg::PhMode: begin
          if (data_byte_i > 8'd1) begin
            fail_en = 1'b1;
            fail_st = stdec_pkg::StBadMode;
          end else if (end_of_file_i) begin
            fail_en = 1'b1;
          end else begin
            state_o.mode_bit     = data_byte_i[0];
            state_o.header_phase = stdec_pkg::PhRsv0;
          end
        end
        stdec_pkg::PhRsv0: begin
          if (end_of_file_i) begin
            fail_en = 1'b1;
          end else begin
            state_o.header_phase = stdec_pkg::PhRsv1;
          end
        end
        stdec_pkg::PhRsv1: begin
          res0_o      = '{code_unit: stdec_pkg::MarkUnit, status: stdec_pkg::StUnit,
                          final_res: 1'b0};
          res_count_o = 2'd1;
          if (end_of_file_i) begin
            res1_o      = '{code_unit: 16'd0, status: stdec_pkg::StDone, final_res: 1'b1};
            res_count_o = 2'd2;
            state_o     = '0;
          end else begin
            state_o.header_phase = stdec_pkg::PhData;
          end
        end
        default: begin
          // data phase: hold a low byte or complete a unit
          if (state_i.half_pending) begin
            res0_o               = '{code_unit: decoded, status: stdec_pkg::StUnit,
                                     final_res: 1'b0};
            res_count_o          = 2'd1;
            state_o.half_pending = 1'b0;
            state_o.low_half     = 8'd0;
          end else begin
            state_o.low_half     = data_byte_i;
            state_o.half_pending = 1'b1;
          end
          if (end_of_file_i) begin
            if (state_i.half_pending) begin
              res1_o      = '{code_unit: 16'd0, status: stdec_pkg::StDone, final_res: 1'b1};
              res_count_o = 2'd2;
            end else begin
              res0_o      = '{code_unit: 16'd0, status: stdec_pkg::StDone, final_res: 1'b1};
              res_count_o = 2'd1;
            end
            state_o = '0;
          end
        end
      endcase

      // Report an error; swallow the rest of the file unless this byte ends it
      if (fail_en) begin
        res0_o             = '{code_unit: 16'd0, status: fail_st, final_res: 1'b1};
        res_count_o        = 2'd1;
        state_o            = '0;
        state_o.discarding = ~end_of_file_i;
      end
    end
  end

endmodule

FILE: src/stdec_queue.sv
`timescale 1ns / 1ps

module stdec_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_count_i,
  input  stdec_pkg::result_t push0_i,
  input  stdec_pkg::result_t push1_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic               valid_o,
  output stdec_pkg::result_t head_o
);

  stdec_pkg::result_t mem_q [stdec_pkg::QueueDepth];

  logic [stdec_pkg::PtrW-1:0] wr_q, wr_d;
  logic [stdec_pkg::PtrW-1:0] rd_q, rd_d;
  logic [stdec_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [stdec_pkg::PtrW-1:0] wr_next;

  assign wr_next = wr_q + stdec_pkg::PtrW'(1);

  // Two free slots guarantee space for the largest burst of one byte
  assign room_o  = cnt_q <= stdec_pkg::CntW'(stdec_pkg::QueueDepth - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_d  = wr_q + stdec_pkg::PtrW'(push_count_i);
    rd_d  = rd_q + stdec_pkg::PtrW'(pop_i);
    cnt_d = cnt_q + stdec_pkg::CntW'(push_count_i) - stdec_pkg::CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_count_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

endmodule

FILE: src/scrambled_text_stream_decoder_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid/tready          tdata[7:0] data_byte, tlast end_of_file
// m_axis    out        tvalid/tready          tdata[15:0] code_unit, tuser[2:0] status,
//                                             tlast final_res
//
// One input byte is taken per cycle; it yields up to two results, which enter a
// four-entry result queue in the same cycle and leave at one per cycle while m_axis_tready is high.
// The input side stalls only while the queue has fewer than two free entries.
// Reset clears the header tracking state and empties the queue.
// A file whose end yields both a unit and a done result pushes both into the queue from one byte.

module scrambled_text_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  stdec_pkg::dec_state_t state_q, state_d;
  stdec_pkg::dec_state_t step_state;
  stdec_pkg::result_t    res0, res1, head;
  logic [1:0]            res_count;
  logic [1:0]            push_count;
  logic                  in_fire;
  logic                  room;

  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid & room;

  stdec_step u_step (
    .state_i       (state_q),
    .data_byte_i   (s_axis_tdata),
    .end_of_file_i (s_axis_tlast),
    .state_o       (step_state),
    .res_count_o   (res_count),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  // Commit state and results only on an input transfer
  assign state_d    = in_fire ? step_state : state_q;
  assign push_count = in_fire ? res_count : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  stdec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .push0_i      (res0),
    .push1_i      (res1),
    .pop_i        (m_axis_tvalid & m_axis_tready),
    .room_o       (room),
    .valid_o      (m_axis_tvalid),
    .head_o       (head)
  );

  assign m_axis_tdata = head.code_unit;
  assign m_axis_tuser = head.status;
  assign m_axis_tlast = head.final_res;

endmodule

FILE: verif/scrambled_text_stream_decoder_core_test.sv
`timescale 1ns / 1ps

module scrambled_text_stream_decoder_core_test;

  localparam int unsigned RandomItems = 1450;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 16;

  // Decoder shadow and store of the results still to arrive
  class stdec_board;
    logic [2:0]         phase;
    logic               mode_sel;
    logic [7:0]         held;
    logic               held_valid;
    logic               swallow;
    stdec_pkg::result_t due_q[$];
    int unsigned        errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase      = stdec_pkg::PhMagic0;
      mode_sel   = 1'b0;
      held       = 8'h00;
      held_valid = 1'b0;
      swallow    = 1'b0;
    endfunction

    function void push_res(logic [15:0] unit, logic [2:0] st, logic fin);
      stdec_pkg::result_t r;
      r.code_unit = unit;
      r.status    = st;
      r.final_res = fin;
      due_q.push_back(r);
    endfunction

    // Report an error and swallow the rest of the file unless this byte ends it
    function void raise_error(logic [2:0] st, logic last);
      push_res(16'h0000, st, 1'b1);
      clear();
      swallow = !last;
    endfunction

    function logic [15:0] unscramble(logic [15:0] u);
      if (mode_sel) begin
        return ((u & stdec_pkg::OddMask) >> 1) | ((u & stdec_pkg::EvenMask) << 1);
      end
      if (u >= stdec_pkg::SmallLimit) begin
        return u ^ ((u & 16'h00FE) << 8) ^ 16'h0001;
      end
      return u;
    endfunction

    // Advance the shadow by one accepted byte and note what it yields
    function void note_input(logic [7:0] b, logic last);
      if (swallow) begin
        if (last) clear();
        return;
      end
      case (phase)
        stdec_pkg::PhMagic0: begin
          if (last) begin
            raise_error(stdec_pkg::StShort, 1'b1);
          end else begin
            held  = {7'd0, b != stdec_pkg::MagicByte};
            phase = stdec_pkg::PhMagic1;
          end
        end
        stdec_pkg::PhMagic1: begin
          if (last) begin
            raise_error(stdec_pkg::StShort, 1'b1);
          end else if (held != 8'h00 || b != stdec_pkg::MagicByte) begin
            raise_error(stdec_pkg::StBadMagic, 1'b0);
          end else begin
            held  = 8'h00;
            phase = stdec_pkg::PhMode;
          end
        end
        stdec_pkg::PhMode: begin
          if (b > 8'd1) begin
            raise_error(stdec_pkg::StBadMode, last);
          end else if (last) begin
            raise_error(stdec_pkg::StShort, 1'b1);
          end else begin
            mode_sel = b[0];
            phase    = stdec_pkg::PhRsv0;
          end
        end
        stdec_pkg::PhRsv0: begin
          if (last) raise_error(stdec_pkg::StShort, 1'b1);
          else phase = stdec_pkg::PhRsv1;
        end
        stdec_pkg::PhRsv1: begin
          push_res(stdec_pkg::MarkUnit, stdec_pkg::StUnit, 1'b0);
          if (last) begin
            push_res(16'h0000, stdec_pkg::StDone, 1'b1);
            clear();
          end else begin
            phase = stdec_pkg::PhData;
          end
        end
        default: begin
          if (held_valid) begin
            push_res(unscramble({b, held}), stdec_pkg::StUnit, 1'b0);
            held_valid = 1'b0;
            held       = 8'h00;
          end else begin
            held       = b;
            held_valid = 1'b1;
          end
          // Drop any odd trailing byte
          if (last) begin
            push_res(16'h0000, stdec_pkg::StDone, 1'b1);
            clear();
          end
        end
      endcase
    endfunction

    function void check_result(logic [15:0] unit, logic [2:0] st, logic fin);
      stdec_pkg::result_t exp_r;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result unit %h status %0d last %0b",
                 $time, unit, st, fin);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (unit !== exp_r.code_unit) begin
        $display("%0t: code_unit expected %h actual %h", $time, exp_r.code_unit, unit);
        errors++;
      end
      if (st !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, st);
        errors++;
      end
      if (fin !== exp_r.final_res) begin
        $display("%0t: final_res expected %0b actual %0b", $time, exp_r.final_res, fin);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data  = 8'h00;
  logic        in_last  = 1'b0;
  logic        out_ready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  wire         m_axis_tlast;

  stdec_board  board = new();
  logic [7:0]  file_q[$];
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          steady    = 1'b0;

  scrambled_text_stream_decoder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tlast  (in_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Offer one byte and hold it until the transfer
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    in_last  <= last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_input(b, last);
    sent_cnt++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) begin
      push_byte(file_q[i], i == file_q.size() - 1);
    end
  endtask

  // Lower valid and hold off until every result has arrived
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic push_header(input logic [7:0] mode);
    file_q.push_back(stdec_pkg::MagicByte);
    file_q.push_back(stdec_pkg::MagicByte);
    file_q.push_back(mode);
    file_q.push_back(8'($urandom));
    file_q.push_back(8'($urandom));
  endtask

  task automatic push_noise(input int max_len);
    int n;
    n = $urandom_range(0, max_len);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  // Build one random file: mostly well-formed, the rest broken
  task automatic build_random_file();
    int kind;
    int units;
    logic [7:0] m0;
    logic [7:0] m1;
    file_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      push_header(8'($urandom_range(0, 1)));
      units = $urandom_range(0, 12);
      repeat (units) begin
        // Favour units near the small-unit boundary
        if ($urandom_range(0, 3) == 0) begin
          file_q.push_back(8'($urandom_range(0, 63)));
          file_q.push_back(8'h00);
        end else begin
          file_q.push_back(8'($urandom));
          file_q.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 1) == 1) file_q.push_back(8'($urandom));
    end else if (kind == 7) begin
      do begin
        m0 = ($urandom_range(0, 1) == 1) ? stdec_pkg::MagicByte : 8'($urandom);
        m1 = ($urandom_range(0, 1) == 1) ? stdec_pkg::MagicByte : 8'($urandom);
      end while (m0 == stdec_pkg::MagicByte && m1 == stdec_pkg::MagicByte);
      file_q.push_back(m0);
      file_q.push_back(m1);
      push_noise(6);
    end else if (kind == 8) begin
      file_q.push_back(stdec_pkg::MagicByte);
      file_q.push_back(stdec_pkg::MagicByte);
      file_q.push_back(8'($urandom_range(2, 255)));
      push_noise(6);
    end else begin
      // Truncated header, sometimes with junk bytes
      push_header(8'($urandom_range(0, 1)));
      units = $urandom_range(1, 4);
      while (file_q.size() > units) void'(file_q.pop_back());
      if ($urandom_range(0, 2) == 0) begin
        foreach (file_q[i]) file_q[i] = 8'($urandom);
      end
    end
  endtask

  // Accept results, stalling a random number of cycles before each
  initial begin : result_sink
    int stall;
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-byte and two-byte files are short whatever they hold
    file_q = '{stdec_pkg::MagicByte};
    send_file();
    file_q = '{stdec_pkg::MagicByte, stdec_pkg::MagicByte};
    send_file();
    // Invalid mode byte as the last byte
    file_q = '{stdec_pkg::MagicByte, stdec_pkg::MagicByte, 8'h02};
    send_file();
    // Bad first magic byte, then a swallowed byte
    file_q = '{8'h00, stdec_pkg::MagicByte, 8'hFF};
    send_file();
    // Header only, bit-pair swap mode
    file_q = '{stdec_pkg::MagicByte, stdec_pkg::MagicByte, 8'h01, 8'hFF, 8'h00};
    send_file();
    // XOR mode: small unit, boundary unit, all ones, odd trailing byte
    file_q = '{stdec_pkg::MagicByte, stdec_pkg::MagicByte, 8'h00, 8'h00, 8'hFF,
               8'h1F, 8'h00, 8'h20, 8'h00, 8'hFF, 8'hFF, 8'h80};
    send_file();

    // Random files
    while (sent_cnt < RandomItems) begin
      if ($urandom_range(0, 7) == 0) steady = !steady;
      build_random_file();
      send_file();
      if (!paused && sent_cnt >= RandomItems / 2) begin
        paused = 1'b1;
        drain_all();
      end
    end

    drain_all();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
